FILE: hdl/spm_pkg.sv
package spm_pkg;

	localparam int TERMS_PER_LIST = 32;
	localparam int IDX_W = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1;
	localparam int CNT_W = $clog2(TERMS_PER_LIST + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] MODE_LOAD_FIRST = 2'd0;
	localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
	localparam logic [1:0] MODE_START = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic signed [31:0] coefficient;
		logic [15:0] exponent;
	} term_item_t;

	typedef struct packed {
		logic signed [32:0] sum_coefficient;
		logic [15:0] sum_exponent;
		logic last_term;
		logic empty_res;
		logic overflow;
	} res_item_t;

	typedef struct packed {
		logic signed [31:0] coefficient;
		logic [15:0] exponent;
	} term_entry_t;

	typedef enum logic [1:0] {
		CMD_LOAD_FIRST,
		CMD_LOAD_SECOND,
		CMD_START
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		term_entry_t entry;
	} cmd_t;

	typedef enum logic [1:0] {
		BACK_IDLE,
		BACK_PRIME,
		BACK_MERGE
	} back_state_t;

endpackage

FILE: hdl/sparse_polynomial_add_merge.sv
// Channel   Direction  Handshake              Payload
// term      in         term_valid/term_stall  term_item_t: mode, coefficient, exponent
// res       out        res_valid/res_stall    res_item_t: sum_coefficient, sum_exponent,
//                                             last_term, empty_res, overflow
//
// Load items stream at one per cycle while the back end is idle.
// A start item with terms first primes the list memory reads, then one result
// leaves per cycle unless res stalls; the single read port of each list sets the rate.
// Reset clears the term counts, the sticky overflow flag and all handshake state;
// the list memories are not cleared, since only entries below a count are read.
// A stall on res holds the output register and the merge; the command queue
// between front and back keeps taking items until it fills.
module sparse_polynomial_add_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                term_valid,
	output logic                term_stall,
	input  spm_pkg::term_item_t term,
	output logic                res_valid,
	input  logic                res_stall,
	output spm_pkg::res_item_t  res
);
	import spm_pkg::*;

	logic front_valid;
	cmd_t front_cmd;
	logic queue_full;
	logic queue_valid;
	cmd_t queue_cmd;
	logic queue_pop;

	// The front end registers each item and drops items with the unused mode code.
	spm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.term_valid (term_valid),
		.term_stall (term_stall),
		.term       (term),
		.cmd_valid  (front_valid),
		.cmd_full   (queue_full),
		.cmd        (front_cmd)
	);

	// A short command queue lets loads arrive while a merge is draining.
	spm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_cmd  (front_cmd),
		.full      (queue_full),
		.pop       (queue_pop),
		.pop_valid (queue_valid),
		.pop_cmd   (queue_cmd)
	);

	// The back end owns the term lists and runs the sorted merge.
	spm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_valid),
		.cmd       (queue_cmd),
		.cmd_pop   (queue_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

FILE: hdl/spm_front.sv
module spm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               term_valid,
	output logic               term_stall,
	input  spm_pkg::term_item_t term,
	output logic               cmd_valid,
	input  logic               cmd_full,
	output spm_pkg::cmd_t      cmd
);
	import spm_pkg::*;

	logic cmd_valid_s1;
	cmd_t cmd_s1;
	logic accept;
	logic known_mode;
	cmd_kind_t kind;

	// The stage holds its command while the queue is full.
	assign term_stall = cmd_valid_s1 && cmd_full;
	assign accept = term_valid && !term_stall;

	always_comb begin
		known_mode = 1'b1;
		kind = CMD_START;
		case (term.mode)
			MODE_LOAD_FIRST:  kind = CMD_LOAD_FIRST;
			MODE_LOAD_SECOND: kind = CMD_LOAD_SECOND;
			MODE_START:       kind = CMD_START;
			default:          known_mode = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (!term_stall) begin
			cmd_valid_s1 <= accept && known_mode;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.kind <= kind;
			cmd_s1.entry.coefficient <= term.coefficient;
			cmd_s1.entry.exponent <= term.exponent;
		end
	end

	assign cmd_valid = cmd_valid_s1;
	assign cmd = cmd_s1;

endmodule

FILE: hdl/spm_queue.sv
module spm_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  spm_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          pop_valid,
	output spm_pkg::cmd_t pop_cmd
);
	import spm_pkg::*;

	cmd_t slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic do_push;
	logic do_pop;

	assign full = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (fill_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && pop_valid;
	assign pop_cmd = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: hdl/spm_back.sv
module spm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  spm_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output logic               res_valid,
	input  logic               res_stall,
	output spm_pkg::res_item_t res
);
	import spm_pkg::*;

	term_entry_t mem_a [TERMS_PER_LIST];
	term_entry_t mem_b [TERMS_PER_LIST];
	term_entry_t rd_a_q;
	term_entry_t rd_b_q;

	back_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_a_q, cnt_a_d;
	logic [CNT_W-1:0] cnt_b_q, cnt_b_d;
	logic [CNT_W-1:0] i_q, i_d, i_nxt;
	logic [CNT_W-1:0] j_q, j_d, j_nxt;
	logic dropped_q, dropped_d;
	logic [IDX_W-1:0] rd_idx_a, rd_idx_b;
	logic wr_a, wr_b;

	logic res_valid_q;
	res_item_t res_q;
	res_item_t res_d;
	logic emit;
	logic out_free;

	logic has_a, has_b, a_gt, b_gt, take_a, take_b;
	logic signed [32:0] coef_a, coef_b;

	assign out_free = !res_valid_q || !res_stall;

	assign has_a = (i_q < cnt_a_q);
	assign has_b = (j_q < cnt_b_q);
	assign a_gt = (rd_a_q.exponent > rd_b_q.exponent);
	assign b_gt = (rd_b_q.exponent > rd_a_q.exponent);
	// Equal exponents take one term from each list.
	assign take_a = has_a && (!has_b || !b_gt);
	assign take_b = has_b && (!has_a || !a_gt);
	assign i_nxt = i_q + CNT_W'(take_a);
	assign j_nxt = j_q + CNT_W'(take_b);
	assign coef_a = {rd_a_q.coefficient[31], rd_a_q.coefficient};
	assign coef_b = {rd_b_q.coefficient[31], rd_b_q.coefficient};

	always_comb begin
		state_d = state_q;
		cnt_a_d = cnt_a_q;
		cnt_b_d = cnt_b_q;
		i_d = i_q;
		j_d = j_q;
		dropped_d = dropped_q;
		rd_idx_a = i_q[IDX_W-1:0];
		rd_idx_b = j_q[IDX_W-1:0];
		wr_a = 1'b0;
		wr_b = 1'b0;
		cmd_pop = 1'b0;
		emit = 1'b0;
		res_d = '0;
		case (state_q)
			BACK_IDLE: begin
				if (cmd_valid) begin
					case (cmd.kind)
						CMD_LOAD_FIRST: begin
							cmd_pop = 1'b1;
							if (cnt_a_q < CNT_W'(TERMS_PER_LIST)) begin
								wr_a = 1'b1;
								cnt_a_d = cnt_a_q + 1'b1;
							end else begin
								dropped_d = 1'b1;
							end
						end
						CMD_LOAD_SECOND: begin
							cmd_pop = 1'b1;
							if (cnt_b_q < CNT_W'(TERMS_PER_LIST)) begin
								wr_b = 1'b1;
								cnt_b_d = cnt_b_q + 1'b1;
							end else begin
								dropped_d = 1'b1;
							end
						end
						CMD_START: begin
							if (cnt_a_q == '0 && cnt_b_q == '0) begin
								if (out_free) begin
									cmd_pop = 1'b1;
									emit = 1'b1;
									res_d.last_term = 1'b1;
									res_d.empty_res = 1'b1;
									res_d.overflow = dropped_q;
								end
							end else begin
								cmd_pop = 1'b1;
								state_d = BACK_PRIME;
							end
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			BACK_PRIME: begin
				state_d = BACK_MERGE;
			end
			BACK_MERGE: begin
				if (out_free) begin
					emit = 1'b1;
					i_d = i_nxt;
					j_d = j_nxt;
					rd_idx_a = i_nxt[IDX_W-1:0];
					rd_idx_b = j_nxt[IDX_W-1:0];
					if (take_a && take_b) begin
						res_d.sum_coefficient = coef_a + coef_b;
						res_d.sum_exponent = rd_a_q.exponent;
					end else if (take_a) begin
						res_d.sum_coefficient = coef_a;
						res_d.sum_exponent = rd_a_q.exponent;
					end else begin
						res_d.sum_coefficient = coef_b;
						res_d.sum_exponent = rd_b_q.exponent;
					end
					res_d.overflow = dropped_q;
					if (i_nxt == cnt_a_q && j_nxt == cnt_b_q) begin
						res_d.last_term = 1'b1;
						state_d = BACK_IDLE;
						i_d = '0;
						j_d = '0;
						cnt_a_d = '0;
						cnt_b_d = '0;
					end
				end
			end
			default: begin
				state_d = BACK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BACK_IDLE;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			i_q <= '0;
			j_q <= '0;
			dropped_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_a_q <= cnt_a_d;
			cnt_b_q <= cnt_b_d;
			i_q <= i_d;
			j_q <= j_d;
			dropped_q <= dropped_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

	// Term lists: one write port for loads, one registered read for the merge.
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[cnt_a_q[IDX_W-1:0]] <= cmd.entry;
		end
		if (wr_b) begin
			mem_b[cnt_b_q[IDX_W-1:0]] <= cmd.entry;
		end
		rd_a_q <= mem_a[rd_idx_a];
		rd_b_q <= mem_b[rd_idx_b];
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule
